// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a given clock and reset
`define KW_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// concurrent check on the block clock and reset
`define KW_ASSERT(label, prop) `KW_ASSERT_CLK(label, clock, reset, prop)

`endif

// File: hw/rtl/kw_pkg.sv
`default_nettype none

package kw_pkg;

   localparam int WIN_LEN   = 12;
   localparam int KEY_COUNT = 11;
   localparam int KEY_W     = 104;
   localparam int FIELD_W   = 24;
   localparam int HIT_W     = 10;
   localparam int PEND_W    = 3;
   localparam int CSR_IDX_W = 2;

   localparam int KEY_JS  = 1;
   localparam int KEY_AA  = 3;
   localparam int KEY_URI = 7;
   localparam int LIN_BIT = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_WARN_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_MID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_HIGH = 2'd2;

   localparam logic [FIELD_W-1:0] WARN_LOW_RESET  = 24'd300;
   localparam logic [FIELD_W-1:0] WARN_MID_RESET  = 24'd800;
   localparam logic [FIELD_W-1:0] WARN_HIGH_RESET = 24'd1500;

   localparam logic [3:0] STREAM_LEN    = 4'd6;
   localparam logic [3:0] ENDSTREAM_LEN = 4'd9;
   localparam logic [3:0] WORD_LEN_MAX  = 4'd15;

   localparam logic [1:0] LEVEL_NONE = 2'd0;
   localparam logic [1:0] LEVEL_LOW  = 2'd1;
   localparam logic [1:0] LEVEL_MID  = 2'd2;
   localparam logic [1:0] LEVEL_HIGH = 2'd3;

   // keyword text right aligned, last character in the low byte
   localparam logic [KEY_W-1:0] KEY_TEXT [KEY_COUNT] = '{
      "/javascript", "/js", "/openaction", "/aa", "/launch",
      "/embeddedfile", "/filespec", "/uri", "/richmedia", "/xfa",
      "/linearized"
   };
   localparam int KEY_LEN [KEY_COUNT] = '{11, 3, 11, 3, 7, 13, 9, 4, 10, 4, 11};

   localparam logic [KEY_COUNT-1:0] SHORT_MASK =
      (KEY_COUNT'(1) << KEY_JS) | (KEY_COUNT'(1) << KEY_AA) | (KEY_COUNT'(1) << KEY_URI);

   typedef struct packed {
      logic [1:0]         pad;
      logic [1:0]         stream_level;
      logic               count_differ;
      logic [FIELD_W-1:0] endstream_count;
      logic [FIELD_W-1:0] stream_count;
      logic               linearized_seen;
      logic [HIT_W-1:0]   pattern_hits;
   } result_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      logic r;
      case (c) inside
         8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0C, 8'h00: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      logic r;
      case (c) inside
         8'h28, 8'h29, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h2F, 8'h25: r = 1'b1;
         default: r = is_ws(c);
      endcase
      return r;
   endfunction

   function automatic logic [KEY_COUNT-1:0] pend_to_hits(input logic [PEND_W-1:0] p);
      logic [KEY_COUNT-1:0] r;
      r = '0;
      r[KEY_JS]  = p[0];
      r[KEY_AA]  = p[1];
      r[KEY_URI] = p[2];
      return r;
   endfunction

   function automatic logic [7:0] stream_char(input logic [3:0] p);
      logic [7:0] r;
      case (p)
         4'd0: r = "s";
         4'd1: r = "t";
         4'd2: r = "r";
         4'd3: r = "e";
         4'd4: r = "a";
         4'd5: r = "m";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] endstream_char(input logic [3:0] p);
      logic [7:0] r;
      case (p)
         4'd0: r = "e";
         4'd1: r = "n";
         4'd2: r = "d";
         4'd3: r = "s";
         4'd4: r = "t";
         4'd5: r = "r";
         4'd6: r = "e";
         4'd7: r = "a";
         4'd8: r = "m";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/kw_cell.sv
`default_nettype none

module kw_cell (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     advance,
   input  wire logic                                     clear,
   input  wire logic [7:0]                               in_byte,
   input  wire logic [kw_pkg::KEY_COUNT-1:0][7:0]        key_chars,
   input  wire logic [kw_pkg::KEY_COUNT-1:0]             key_care,
   output logic      [7:0]                               out_byte,
   output logic      [kw_pkg::KEY_COUNT-1:0]             eq
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      for (int i = 0; i < kw_pkg::KEY_COUNT; i++) begin
         eq[i] = !key_care[i] || (in_byte == key_chars[i]);
      end
   end

   always_comb begin
      byte_in = byte_ff;
      if (clear) begin
         byte_in = 8'h00;
      end else if (advance) begin
         byte_in = in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign out_byte = byte_ff;

endmodule

`default_nettype wire

// File: hw/rtl/kw_word.sv
`default_nettype none

module kw_word #(
   parameter int COUNT_WIDTH = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   last,
   input  wire logic [7:0]             byte_folded,
   output logic      [COUNT_WIDTH-1:0] stream_total,
   output logic      [COUNT_WIDTH-1:0] endstream_total
);

   logic [3:0]             len_ff, len_in;
   logic                   is_s_ff, is_s_in;
   logic                   is_e_ff, is_e_in;
   logic [COUNT_WIDTH-1:0] scount_ff, scount_in;
   logic [COUNT_WIDTH-1:0] ecount_ff, ecount_in;

   logic       ws;
   logic       new_s, new_e;
   logic [3:0] new_len;
   logic       s_inc, e_inc;

   always_comb begin
      ws      = kw_pkg::is_ws(byte_folded);
      new_s   = is_s_ff && (len_ff < kw_pkg::STREAM_LEN)
                && (byte_folded == kw_pkg::stream_char(len_ff));
      new_e   = is_e_ff && (len_ff < kw_pkg::ENDSTREAM_LEN)
                && (byte_folded == kw_pkg::endstream_char(len_ff));
      new_len = (len_ff == kw_pkg::WORD_LEN_MAX) ? len_ff : len_ff + 4'd1;
      if (ws) begin
         s_inc = is_s_ff && (len_ff == kw_pkg::STREAM_LEN);
         e_inc = is_e_ff && (len_ff == kw_pkg::ENDSTREAM_LEN);
      end else begin
         s_inc = last && new_s && (new_len == kw_pkg::STREAM_LEN);
         e_inc = last && new_e && (new_len == kw_pkg::ENDSTREAM_LEN);
      end
      stream_total    = scount_ff + COUNT_WIDTH'(s_inc && !(&scount_ff));
      endstream_total = ecount_ff + COUNT_WIDTH'(e_inc && !(&ecount_ff));
   end

   always_comb begin
      len_in    = len_ff;
      is_s_in   = is_s_ff;
      is_e_in   = is_e_ff;
      scount_in = scount_ff;
      ecount_in = ecount_ff;
      if (advance) begin
         if (last) begin
            len_in    = 4'd0;
            is_s_in   = 1'b1;
            is_e_in   = 1'b1;
            scount_in = '0;
            ecount_in = '0;
         end else if (ws) begin
            len_in    = 4'd0;
            is_s_in   = 1'b1;
            is_e_in   = 1'b1;
            scount_in = stream_total;
            ecount_in = endstream_total;
         end else begin
            len_in  = new_len;
            is_s_in = new_s;
            is_e_in = new_e;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= 4'd0;
         is_s_ff   <= 1'b1;
         is_e_ff   <= 1'b1;
         scount_ff <= '0;
         ecount_ff <= '0;
      end else begin
         len_ff    <= len_in;
         is_s_ff   <= is_s_in;
         is_e_ff   <= is_e_in;
         scount_ff <= scount_in;
         ecount_ff <= ecount_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/pdf_keyword_scanner_top.sv
`default_nettype none

// keyword scanner for pdf byte buffers
// req channel: one file byte per item in req_tdata, req_tlast on the final byte
//   of a buffer. letters match without regard to case.
// rsp channel: one item per buffer, issued for the item that carries req_tlast:
//   keyword hit mask, /linearized flag, whole-word stream and endstream counts
//   (saturating), their mismatch flag and a stream count level from warn_low,
//   warn_mid and warn_high. after that item all scan state starts over.
// csr channel: csr_index 0..2 selects warn_low, warn_mid, warn_high; always ready.
// throughput: one byte per clock unless a pending result stalls the input,
//   through a row of twelve byte cells that shift the window and compare
//   the byte entering each cell against the keyword characters of its position.
// latency: the result is valid in the cycle after the final byte is taken.
// stall: the result waits in the output register; a new byte is taken while
//   rsp_tready is high or no result is pending.
// reset: thresholds return to 300, 800 and 1500, window, word state, hits and
//   counts clear, no result is pending.

module pdf_keyword_scanner_top #(
   parameter int COUNT_WIDTH = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // byte_value
   input  wire logic                              req_tlast,   // last_byte
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // pattern_hits[9:0], linearized_seen, stream_count[23:0],
   // endstream_count[23:0], count_differ, stream_level[1:0], zero pad
   output logic      [63:0]                       rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [kw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [kw_pkg::FIELD_W-1:0]        csr_data
);

   localparam int CMP_W = (COUNT_WIDTH > kw_pkg::FIELD_W) ? COUNT_WIDTH : kw_pkg::FIELD_W;
   localparam int NK    = kw_pkg::KEY_COUNT;
   localparam int NW    = kw_pkg::WIN_LEN;

   logic [kw_pkg::FIELD_W-1:0] warn_low_ff, warn_low_in;
   logic [kw_pkg::FIELD_W-1:0] warn_mid_ff, warn_mid_in;
   logic [kw_pkg::FIELD_W-1:0] warn_high_ff, warn_high_in;

   logic [NK-1:0]                 hit_ff, hit_in;
   logic [kw_pkg::PEND_W-1:0]     pend_ff, pend_in;
   kw_pkg::result_type            rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          accept;
   logic                          clear;
   logic [7:0]                    folded;
   logic [7:0]                    chain [NW+1];
   logic [NK-1:0]                 eq [NW+1];
   logic [NK-1:0][7:0]            cell_chars [NW+1];
   logic [NK-1:0]                 cell_care [NW+1];
   logic [NK-1:0]                 match;
   logic [kw_pkg::PEND_W-1:0]     new_pend;
   logic [NK-1:0]                 hits_now;
   logic [NK-1:0]                 hits_final;
   logic [COUNT_WIDTH-1:0]        stream_total, endstream_total;
   logic [CMP_W-1:0]              s_wide, e_wide;
   logic [1:0]                    level;

   assign accept     = req_tvalid && req_tready;
   assign clear      = accept && req_tlast;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign folded     = kw_pkg::fold_case(req_tdata);
   assign chain[0]   = folded;

   // window cells, cell d compares the byte d positions back from the newest
   for (genvar d = 0; d <= NW; d++) begin : g_key
      for (genvar i = 0; i < NK; i++) begin : g_chr
         assign cell_chars[d][i] = kw_pkg::KEY_TEXT[i][8*d +: 8];
         assign cell_care[d][i]  = (d < kw_pkg::KEY_LEN[i]);
      end
   end

   for (genvar d = 0; d < NW; d++) begin : g_cell
      kw_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (accept),
         .clear     (clear),
         .in_byte   (chain[d]),
         .key_chars (cell_chars[d]),
         .key_care  (cell_care[d]),
         .out_byte  (chain[d+1]),
         .eq        (eq[d])
      );
   end

   for (genvar i = 0; i < NK; i++) begin : g_oldest
      assign eq[NW][i] = !cell_care[NW][i] || (chain[NW] == cell_chars[NW][i]);
   end

   always_comb begin
      match = '1;
      for (int d = 0; d <= NW; d++) begin
         match = match & eq[d];
      end
   end

   kw_word #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_word (
      .clock           (clock),
      .reset           (reset),
      .advance         (accept),
      .last            (req_tlast),
      .byte_folded     (folded),
      .stream_total    (stream_total),
      .endstream_total (endstream_total)
   );

   always_comb begin
      new_pend = {match[kw_pkg::KEY_URI], match[kw_pkg::KEY_AA], match[kw_pkg::KEY_JS]};
      hits_now = hit_ff | (match & ~kw_pkg::SHORT_MASK);
      if (kw_pkg::is_delim(req_tdata)) begin
         hits_now = hits_now | kw_pkg::pend_to_hits(pend_ff);
      end
      hits_final = hits_now | kw_pkg::pend_to_hits(new_pend);
      s_wide     = CMP_W'(stream_total);
      e_wide     = CMP_W'(endstream_total);
      if (s_wide >= CMP_W'(warn_high_ff)) begin
         level = kw_pkg::LEVEL_HIGH;
      end else if (s_wide >= CMP_W'(warn_mid_ff)) begin
         level = kw_pkg::LEVEL_MID;
      end else if (s_wide >= CMP_W'(warn_low_ff)) begin
         level = kw_pkg::LEVEL_LOW;
      end else begin
         level = kw_pkg::LEVEL_NONE;
      end
   end

   always_comb begin
      hit_in  = hit_ff;
      pend_in = pend_ff;
      if (accept) begin
         if (req_tlast) begin
            hit_in  = '0;
            pend_in = '0;
         end else begin
            hit_in  = hits_now;
            pend_in = new_pend;
         end
      end
   end

   always_comb begin
      rsp_in                 = rsp_ff;
      rsp_valid_in           = rsp_valid_ff;
      if (clear) begin
         rsp_in.pad             = 2'b00;
         rsp_in.pattern_hits    = hits_final[kw_pkg::HIT_W-1:0];
         rsp_in.linearized_seen = hits_final[kw_pkg::LIN_BIT];
         rsp_in.stream_count    = s_wide[kw_pkg::FIELD_W-1:0];
         rsp_in.endstream_count = e_wide[kw_pkg::FIELD_W-1:0];
         rsp_in.count_differ    = (stream_total != endstream_total);
         rsp_in.stream_level    = level;
         rsp_valid_in           = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in           = 1'b0;
      end
   end

   always_comb begin
      warn_low_in  = warn_low_ff;
      warn_mid_in  = warn_mid_ff;
      warn_high_in = warn_high_ff;
      if (csr_valid) begin
         unique case (csr_index)
            kw_pkg::CSR_WARN_LOW:  warn_low_in  = csr_data;
            kw_pkg::CSR_WARN_MID:  warn_mid_in  = csr_data;
            kw_pkg::CSR_WARN_HIGH: warn_high_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_low_ff  <= kw_pkg::WARN_LOW_RESET;
         warn_mid_ff  <= kw_pkg::WARN_MID_RESET;
         warn_high_ff <= kw_pkg::WARN_HIGH_RESET;
         hit_ff       <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         warn_low_ff  <= warn_low_in;
         warn_mid_ff  <= warn_mid_in;
         warn_high_ff <= warn_high_in;
         hit_ff       <= hit_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

`default_nettype wire

// File: hw/rtl/kw_checker.sv
`default_nettype none

`include "assert_macros.svh"

module kw_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);

   `KW_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `KW_ASSERT(a_last_gives_rsp, req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
   `KW_ASSERT(a_no_spurious_rsp, !(req_tvalid && req_tready && req_tlast) && !(rsp_tvalid && !rsp_tready) |=> !rsp_tvalid)
   `KW_ASSERT(a_stall_blocks_req, rsp_tvalid && !rsp_tready |-> !req_tready)

endmodule

bind pdf_keyword_scanner_top kw_checker u_kw_checker (.*);

`default_nettype wire
